### hw/rtl/kxb_pkg.sv
// Package for the keyed XOR / Base64 token generator.
// Holds the transaction structs, action codes, sequencer states and character helpers.
// No dependencies.
package kxb_pkg;

  localparam int KEY_LEN_W     = 7;
  localparam int VERSION_BYTES = 16;
  localparam int TOKEN_BYTES   = 20;
  localparam int PASS_STEPS    = 2 * TOKEN_BYTES;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [1:0] ACT_KEY  = 2'd0;
  localparam logic [1:0] ACT_VER  = 2'd1;
  localparam logic [1:0] ACT_GEN  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [0:0]           REG_KEY_LENGTH   = 1'b0;
  localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = 7'd1;

  localparam logic [2:0] LAST_GROUP = 3'd6;
  localparam logic [6:0] CHAR_PAD   = 7'h3d;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  byte_index;
    logic [7:0]  byte_value;
    logic [31:0] seed;
  } in_item_t;

  typedef struct packed {
    logic [6:0] token_char;
    logic       last_char;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PASS,
    ST_LOAD,
    ST_EMIT
  } seq_state_t;

  // lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'b0, n};
    end else begin
      c = 8'h57 + {4'b0, n};
    end
    return c;
  endfunction

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    priority if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h47 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      c = 7'h2b;
    end else begin
      c = 7'h2f;
    end
    return c;
  endfunction

endpackage

### hw/rtl/keyed_xor_base64_token.sv
// Top level of the keyed XOR / Base64 token generator.
// Depends on kxb_pkg and kxb_ram (key store and work buffer).
//
// Key and version writes are taken straight from the input while the block is idle. A
// generate transaction occupies the block: it seeds the work buffer, runs the two key
// passes (one read-modify-write per buffer byte per pass through the work RAM port)
// and then handles the seven output 3-byte groups (three RAM reads, four characters
// each). These steps share the single read port of the work RAM. No new input is
// taken until the last character sits in the output register; output stalls
// lengthen the transaction. key_length of 0 acts as 1, values above
// KEY_BYTES_MAX saturate. Key bytes never written read as unknown.
module keyed_xor_base64_token import kxb_pkg::*; #(
  parameter int KEY_BYTES_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int KW = $clog2(KEY_BYTES_MAX);

  seq_state_t state_r, state_nxt;

  logic [KEY_LEN_W-1:0] key_length_r;
  logic [KW-1:0]        klim_m1;
  logic [7:0]           ver_r [VERSION_BYTES];
  logic [31:0]          seed_r;

  logic [5:0]    step_r, step_nxt;
  logic [KW-1:0] kidx_r, kidx_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [4:0]    wr_addr_r, wr_addr_nxt;
  logic          fwd_r, fwd_nxt;
  logic [7:0]    fwd_data_r, fwd_data_nxt;
  logic [4:0]    bp_r, bp_nxt;
  logic [1:0]    lc_r, lc_nxt;
  logic [1:0]    cc_r, cc_nxt;
  logic [2:0]    g_r, g_nxt;
  logic [23:0]   grp_r, grp_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          in_acc;
  logic          cfg_wr;
  logic          out_free;
  logic          key_we;
  logic [KW-1:0] key_waddr;
  logic [7:0]    key_rd;
  logic          work_we;
  logic [4:0]    work_waddr;
  logic [7:0]    work_wdata;
  logic [4:0]    work_raddr;
  logic [7:0]    work_rd;
  logic [4:0]    pass_addr;
  logic [7:0]    pass_wdata;
  logic [7:0]    init_byte;
  logic [4:0]    init_i;
  logic [7:0]    cap_byte;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_ADDR_W-1:2] == REG_KEY_LENGTH);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_KEY_LENGTH) ?
                      32'(key_length_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LENGTH_RESET;
    end else if (cfg_wr) begin
      key_length_r <= cfg_pwdata[KEY_LEN_W-1:0];
    end
  end

  always_comb begin
    if (32'(key_length_r) > 32'(KEY_BYTES_MAX)) begin
      klim_m1 = KW'(KEY_BYTES_MAX - 1);
    end else if (key_length_r == '0) begin
      klim_m1 = '0;
    end else begin
      klim_m1 = KW'(key_length_r - 7'd1);
    end
  end

  // ---------------------------------------------------------------- input side
  assign in_acc    = in_valid && !in_stall;
  assign key_we    = in_acc && (in_item.action == ACT_KEY) &&
                     (32'(in_item.byte_index) < 32'(KEY_BYTES_MAX));
  assign key_waddr = KW'(in_item.byte_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VERSION_BYTES; i++) begin
        ver_r[i] <= 8'd0;
      end
    end else if (in_acc && (in_item.action == ACT_VER) &&
                 (in_item.byte_index[5:4] == 2'b00)) begin
      ver_r[in_item.byte_index[3:0]] <= in_item.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_item.action == ACT_GEN)) begin
      seed_r <= in_item.seed;
    end
  end

  // ---------------------------------------------------------------- memories
  kxb_ram #(.WIDTH(8), .DEPTH(KEY_BYTES_MAX)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_item.byte_value),
    .raddr (kidx_r),
    .rdata (key_rd)
  );

  kxb_ram #(.WIDTH(8), .DEPTH(TOKEN_BYTES)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wdata),
    .raddr (work_raddr),
    .rdata (work_rd)
  );

  // ---------------------------------------------------------------- datapath terms
  // version byte i gets hex digits i mod 8 and 7 - (i mod 8); tail is the seed, big-endian
  assign init_i = step_r[4:0];
  always_comb begin
    if (init_i < 5'd16) begin
      init_byte = ver_r[init_i[3:0]]
                ^ hex_char(4'(seed_r >> {~init_i[2:0], 2'b00}))
                ^ hex_char(4'(seed_r >> {init_i[2:0], 2'b00}));
    end else begin
      init_byte = 8'(seed_r >> {~init_i[1:0], 3'b000});
    end
  end

  assign pass_addr  = (step_r < 6'(TOKEN_BYTES)) ? step_r[4:0] :
                      5'(6'(PASS_STEPS - 1) - step_r);
  assign pass_wdata = (fwd_r ? fwd_data_r : work_rd) ^ key_rd;
  assign cap_byte   = ((g_r == LAST_GROUP) && (lc_r == 2'd3)) ? 8'd0 : work_rd;
  assign out_free   = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_item.action == ACT_GEN)) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (step_r == 6'(TOKEN_BYTES - 1)) begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        if (step_r == 6'(PASS_STEPS)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (lc_r == 2'd3) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (cc_r == 2'd3)) begin
          state_nxt = (g_r == LAST_GROUP) ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_stall   = 1'b1;
    work_we    = 1'b0;
    work_waddr = wr_addr_r;
    work_wdata = pass_wdata;
    work_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_INIT: begin
        work_we    = 1'b1;
        work_waddr = init_i;
        work_wdata = init_byte;
      end
      ST_PASS: begin
        work_we    = wr_pend_r;
        work_raddr = pass_addr;
      end
      ST_LOAD: begin
        work_raddr = (bp_r == 5'(TOKEN_BYTES)) ? '0 : bp_r;
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- counters and buffers
  always_comb begin
    step_nxt      = step_r;
    kidx_nxt      = kidx_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    fwd_nxt       = 1'b0;
    fwd_data_nxt  = fwd_data_r;
    bp_nxt        = bp_r;
    lc_nxt        = lc_r;
    cc_nxt        = cc_r;
    g_nxt         = g_r;
    grp_nxt       = grp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        kidx_nxt = '0;
        bp_nxt   = '0;
        lc_nxt   = '0;
        cc_nxt   = '0;
        g_nxt    = '0;
      end
      ST_INIT: begin
        step_nxt = (step_r == 6'(TOKEN_BYTES - 1)) ? 6'd0 : step_r + 6'd1;
      end
      ST_PASS: begin
        if (step_r != 6'(PASS_STEPS)) begin
          step_nxt     = step_r + 6'd1;
          wr_pend_nxt  = 1'b1;
          wr_addr_nxt  = pass_addr;
          // write in flight to the entry read now: hand its data over
          fwd_nxt      = wr_pend_r && (wr_addr_r == pass_addr);
          fwd_data_nxt = pass_wdata;
          kidx_nxt     = ((step_r == 6'(TOKEN_BYTES - 1)) || (kidx_r == klim_m1)) ?
                         '0 : kidx_r + KW'(1);
        end
      end
      ST_LOAD: begin
        if (lc_r != 2'd3) begin
          bp_nxt = bp_r + 5'd1;
        end
        if (lc_r != 2'd0) begin
          grp_nxt = {grp_r[15:0], cap_byte};
        end
        lc_nxt = lc_r + 2'd1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if ((g_r == LAST_GROUP) && (cc_r == 2'd3)) begin
            out_nxt.token_char = CHAR_PAD;
            out_nxt.last_char  = 1'b1;
          end else begin
            out_nxt.token_char = b64_char(grp_r[23:18]);
            out_nxt.last_char  = 1'b0;
          end
          grp_nxt = {grp_r[17:0], 6'd0};
          cc_nxt  = cc_r + 2'd1;
          if (cc_r == 2'd3) begin
            g_nxt = g_r + 3'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      kidx_r      <= '0;
      wr_pend_r   <= 1'b0;
      wr_addr_r   <= '0;
      fwd_r       <= 1'b0;
      bp_r        <= '0;
      lc_r        <= '0;
      cc_r        <= '0;
      g_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      kidx_r      <= kidx_nxt;
      wr_pend_r   <= wr_pend_nxt;
      wr_addr_r   <= wr_addr_nxt;
      fwd_r       <= fwd_nxt;
      bp_r        <= bp_nxt;
      lc_r        <= lc_nxt;
      cc_r        <= cc_nxt;
      g_r         <= g_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= fwd_data_nxt;
    grp_r      <= grp_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // ---------------------------------------------------------------- assertions
  a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_char |-> out_item.token_char == CHAR_PAD)
    else $error("last character is not the pad character");

  a_gen_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.action == ACT_GEN) |=> state_r == ST_INIT)
    else $error("generate transaction did not start the sequencer");

  a_kidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PASS |-> kidx_r <= klim_m1)
    else $error("key index beyond key length");

  a_fwd_with_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> wr_pend_r && (state_r == ST_PASS))
    else $error("forwarded data without a pending write");

  a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> g_r <= LAST_GROUP)
    else $error("group counter overran the token");

endmodule

### hw/rtl/kxb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kxb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
